FILE: hw/rtl/trpc_pkg.sv
`default_nettype none
package trpc_pkg;
    localparam int NW = 32;
    localparam int DW = 31;
    localparam int WW = 34;
    typedef logic [WW-1:0] t_word;

    typedef enum logic [2:0] {
        FC_SIN = 3'd0, FC_COS = 3'd1, FC_TAN = 3'd2,
        FC_COT = 3'd3, FC_SEC = 3'd4, FC_CSC = 3'd5
    } t_func;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MOD_INIT, OP_MOD_STEP, OP_FOLD,
        OP_GCD_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE,
        OP_COMP_INIT, OP_PICK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_b;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic gcd_done;
        logic gcd_one;
        logic n_zero;
    } t_stat;
endpackage
`default_nettype wire

FILE: hw/rtl/trpc_datapath.sv
`default_nettype none
module trpc_datapath (
    input  wire logic                  i_clk,
    input  wire logic [2:0]            i_func_code,
    input  wire logic [trpc_pkg::NW-1:0] i_numer,
    input  wire logic [trpc_pkg::DW-1:0] i_denom,
    input  wire trpc_pkg::t_cmd        i_cmd,
    output      trpc_pkg::t_stat       o_stat,
    output      logic [2:0]            o_func,
    output      logic [30:0]           o_numer,
    output      logic [31:0]           o_denom,
    output      logic                  o_neg,
    output      logic                  o_bad
);
    localparam int CW = $clog2(trpc_pkg::WW + 1);
    trpc_pkg::t_word r_n, r_d, r_a, r_b, r_q, r_rem, r_div, r_an, r_ad, r_n0, r_d0;
    logic [2:0] r_fc;
    logic r_neg, r_negin, r_sel;
    logic [CW-1:0] r_cnt;
    logic [trpc_pkg::NW-1:0] r_raw;
    trpc_pkg::t_word trial, rem_sh, mag;

    assign mag = r_raw[trpc_pkg::NW-1]
        ? trpc_pkg::WW'((~{2'b0, r_raw}) + 1'b1) & {{(trpc_pkg::WW-trpc_pkg::NW){1'b0}},
            {trpc_pkg::NW{1'b1}}}
        : {{(trpc_pkg::WW-trpc_pkg::NW){1'b0}}, r_raw};
    assign rem_sh = {r_rem[trpc_pkg::WW-2:0], r_q[trpc_pkg::WW-1]};
    assign trial  = rem_sh - r_div;

    assign o_stat.bad      = o_bad;
    assign o_stat.div_done = (r_cnt == '0);
    assign o_stat.gcd_done = (r_b == '0);
    assign o_stat.gcd_one  = (r_a == trpc_pkg::t_word'(1));
    assign o_stat.n_zero   = (r_n == '0);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            trpc_pkg::OP_LOAD: begin
                r_fc  <= i_func_code;
                r_raw <= i_numer;
                r_d   <= {3'b0, i_denom};
                r_neg <= 1'b0;
                o_bad <= (i_denom == '0) || (i_func_code > trpc_pkg::FC_CSC);
            end
            trpc_pkg::OP_MOD_INIT: begin
                r_q   <= mag;
                r_rem <= '0;
                r_div <= (r_fc == trpc_pkg::FC_TAN || r_fc == trpc_pkg::FC_COT)
                    ? r_d : {r_d[trpc_pkg::WW-2:0], 1'b0};
                r_cnt <= CW'(trpc_pkg::WW);
                r_negin <= r_raw[trpc_pkg::NW-1];
            end
            trpc_pkg::OP_DIV_INIT: begin
                r_q   <= i_cmd.sel_b ? r_d : r_n;
                r_rem <= '0;
                r_div <= r_a;
                r_cnt <= CW'(trpc_pkg::WW);
            end
            trpc_pkg::OP_MOD_STEP, trpc_pkg::OP_DIV_STEP: begin
                if (!trial[trpc_pkg::WW-1] || rem_sh >= r_div) begin
                    r_rem <= (rem_sh >= r_div) ? trial : rem_sh;
                    r_q   <= {r_q[trpc_pkg::WW-2:0], rem_sh >= r_div};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[trpc_pkg::WW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
            end
            trpc_pkg::OP_FOLD: begin
                trpc_pkg::t_word m, n1, d2;
                m  = (r_negin && r_rem != '0) ? r_div - r_rem : r_rem;
                d2 = {r_d[trpc_pkg::WW-2:0], 1'b0};
                n1 = m;
                if (r_fc == trpc_pkg::FC_TAN || r_fc == trpc_pkg::FC_COT) begin
                    if ({n1[trpc_pkg::WW-2:0], 1'b0} > r_d) begin
                        r_neg <= 1'b1; n1 = r_d - n1;
                    end
                end else if (r_fc == trpc_pkg::FC_SIN || r_fc == trpc_pkg::FC_CSC) begin
                    if (n1 > r_d) begin r_neg <= 1'b1; n1 = n1 - r_d; end
                    if ({n1[trpc_pkg::WW-2:0], 1'b0} > r_d) n1 = r_d - n1;
                end else begin
                    if (n1 > r_d) n1 = d2 - n1;
                    if ({n1[trpc_pkg::WW-2:0], 1'b0} > r_d) begin
                        r_neg <= 1'b1; n1 = r_d - n1;
                    end
                end
                r_n <= n1;
                r_a <= n1;
                r_b <= r_d;
                r_sel <= 1'b0;
            end
            trpc_pkg::OP_GCD_STEP: begin
                if (r_cnt == '0) begin
                    r_q   <= r_a;
                    r_rem <= '0;
                    r_div <= r_b;
                    r_cnt <= CW'(trpc_pkg::WW);
                end
            end
            trpc_pkg::OP_DIV_DONE: begin
                if (i_cmd.sel_b) r_d <= r_q; else r_n <= r_q;
            end
            trpc_pkg::OP_COMP_INIT: begin
                r_n0 <= r_n;
                r_d0 <= r_d;
                r_n  <= r_d - {r_n[trpc_pkg::WW-2:0], 1'b0};
                r_d  <= {r_d[trpc_pkg::WW-2:0], 1'b0};
                r_a  <= r_d - {r_n[trpc_pkg::WW-2:0], 1'b0};
                r_b  <= {r_d[trpc_pkg::WW-2:0], 1'b0};
                r_sel <= 1'b1;
            end
            trpc_pkg::OP_PICK: begin
                if (o_bad) begin
                    o_func <= '0; o_numer <= '0; o_denom <= '0; o_neg <= 1'b0;
                end else if (!r_sel) begin
                    o_func <= r_fc; o_numer <= 31'(r_n); o_denom <= 32'd1;
                    o_neg <= r_neg;
                end else begin
                    o_neg <= r_neg;
                    if (r_n < r_n0) begin
                        o_func  <= r_fc ^ 3'd1;
                        o_numer <= 31'(r_n);
                        o_denom <= (r_n == '0) ? 32'd1 : 32'(r_d);
                    end else begin
                        o_func  <= r_fc;
                        o_numer <= 31'(r_n0);
                        o_denom <= 32'(r_d0);
                    end
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.op == trpc_pkg::OP_GCD_STEP && r_cnt != '0) begin
            if (rem_sh >= r_div) begin
                r_rem <= trial;
                r_q   <= {r_q[trpc_pkg::WW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[trpc_pkg::WW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_a <= r_b;
                r_b <= (rem_sh >= r_div) ? trial : rem_sh;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/trpc_ctrl.sv
`default_nettype none
module trpc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_out_stall,
    input  wire trpc_pkg::t_stat i_stat,
    output      logic           o_stall,
    output      logic           o_valid,
    output      trpc_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MINIT, S_MOD, S_FOLD, S_GCD, S_DIVN, S_DIVD,
        S_NEXT, S_PICK, S_OUT
    } t_state;
    t_state r_state;
    logic   r_comp, r_side;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '{op: trpc_pkg::OP_NONE, sel_b: (r_state == S_DIVD)};
        case (r_state)
            S_IDLE:  if (i_valid) o_cmd.op = trpc_pkg::OP_LOAD;
            S_MINIT: o_cmd.op = trpc_pkg::OP_MOD_INIT;
            S_MOD:   o_cmd.op = i_stat.div_done ? trpc_pkg::OP_FOLD : trpc_pkg::OP_MOD_STEP;
            S_GCD:   if (!i_stat.gcd_done || !i_stat.div_done)
                         o_cmd.op = trpc_pkg::OP_GCD_STEP;
                     else if (!i_stat.gcd_one) o_cmd.op = trpc_pkg::OP_DIV_INIT;
            S_DIVN:  o_cmd.op = i_stat.div_done ? trpc_pkg::OP_DIV_DONE
                                                : trpc_pkg::OP_DIV_STEP;
            S_DIVD:  if (r_side) o_cmd.op = trpc_pkg::OP_DIV_INIT;
                     else o_cmd.op = i_stat.div_done ? trpc_pkg::OP_DIV_DONE
                                                     : trpc_pkg::OP_DIV_STEP;
            S_NEXT:  if (!i_stat.n_zero && !r_comp) o_cmd.op = trpc_pkg::OP_COMP_INIT;
            S_PICK:  o_cmd.op = trpc_pkg::OP_PICK;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_comp  <= 1'b0;
            r_side  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_state <= S_CHECK; r_comp <= 1'b0;
                end
                S_CHECK: r_state <= i_stat.bad ? S_PICK : S_MINIT;
                S_MINIT: r_state <= S_MOD;
                S_MOD:   if (i_stat.div_done) r_state <= S_GCD;
                S_GCD:   if (i_stat.gcd_done && i_stat.div_done) begin
                    if (i_stat.gcd_one) r_state <= S_NEXT;
                    else begin r_state <= S_DIVN; r_side <= 1'b0; end
                end
                S_DIVN:  if (i_stat.div_done) begin
                    r_state <= S_DIVD; r_side <= 1'b1;
                end
                S_DIVD:  if (r_side) begin
                    r_side <= 1'b0;
                end else if (i_stat.div_done) r_state <= S_NEXT;
                S_NEXT: begin
                    if (i_stat.n_zero || r_comp) r_state <= S_PICK;
                    else begin r_comp <= 1'b1; r_state <= S_GCD; end
                end
                S_PICK: begin r_state <= S_OUT; o_valid <= 1'b1; end
                S_OUT: if (!i_out_stall) begin
                    o_valid <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/trig_rational_pi_canonicalizer.sv
// Trig canonicalizer for rational multiples of pi.
// Input channel: i_valid / o_stall with i_func_code, i_numer, i_denom.
// Output channel: o_valid / i_stall with o_valid_res, o_func_out,
// o_numer_out, o_denom_out, o_negate.
// One beat is worked at a time by a shared restoring divider (one bit
// per cycle): a modulo pass, a gcd for the angle and, if it is not one,
// two divides by it; a nonzero angle then gets the same for its complement.
// A zero denominator or unknown code goes from the check state
// straight to the pick state. Otherwise the time taken grows with the
// number of gcd remainder steps (up to about 45 per gcd at 31- and
// 32-bit operands).
// Throughput: one beat in flight; the next beat is accepted the cycle
// after the result beat is taken.
// o_stall is high from acceptance until the result beat is taken.
// The result holds on the output while i_stall is high.
// Reset (synchronous, active low) drops any beat in flight.
// A zero denominator or unknown code gives o_valid_res low.
`default_nettype none
module trig_rational_pi_canonicalizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [2:0]  i_func_code,
    input  wire logic [31:0] i_numer,
    input  wire logic [30:0] i_denom,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic        o_valid_res,
    output      logic [2:0]  o_func_out,
    output      logic [30:0] o_numer_out,
    output      logic [31:0] o_denom_out,
    output      logic        o_negate
);
    trpc_pkg::t_cmd  cmd;
    trpc_pkg::t_stat stat;
    logic bad;

    trpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_stall(i_stall), .i_stat(stat), .o_stall(o_stall),
        .o_valid(o_valid), .o_cmd(cmd)
    );

    trpc_datapath u_dp (
        .i_clk(i_clk), .i_func_code(i_func_code), .i_numer(i_numer),
        .i_denom(i_denom), .i_cmd(cmd), .o_stat(stat),
        .o_func(o_func_out), .o_numer(o_numer_out), .o_denom(o_denom_out),
        .o_neg(o_negate), .o_bad(bad)
    );

    assign o_valid_res = !bad;
endmodule
`default_nettype wire

FILE: hw/rtl/trpc_checker.sv
`default_nettype none
module trpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_valid_res,
    input wire logic [30:0] o_numer_out,
    input wire logic [31:0] o_denom_out
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("output pending while input open");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_numer_out))
        else $error("stalled result changed");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_denom_out != '0)
        else $error("zero denominator out");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("accept not held");
endmodule
bind trig_rational_pi_canonicalizer trpc_checker u_chk (.*);
`default_nettype wire

FILE: tb/tb_trig_rational_pi_canonicalizer.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_trig_rational_pi_canonicalizer;
    localparam int LIMIT_CYCLES = 40_000_000;
    localparam int RAND_ITEMS   = 1520;
    localparam int HOLD_CYCLES  = 3000;

    typedef struct {
        logic        valid_res;
        logic [2:0]  func_out;
        logic [30:0] numer_out;
        logic [31:0] denom_out;
        logic        negate;
    } t_canon;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func_code = '0;
    logic [31:0] i_numer = '0;
    logic [30:0] i_denom = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_valid_res;
    logic [2:0]  o_func_out;
    logic [30:0] o_numer_out;
    logic [31:0] o_denom_out;
    logic        o_negate;

    t_canon angle_q[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_rejected = 0;
    int     n_swapped = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    longint cycles = 0;

    trig_rational_pi_canonicalizer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func_code(i_func_code), .i_numer(i_numer), .i_denom(i_denom),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_valid_res(o_valid_res), .o_func_out(o_func_out),
        .o_numer_out(o_numer_out), .o_denom_out(o_denom_out),
        .o_negate(o_negate)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_canon canon_angle(logic [2:0] fc, logic [31:0] nraw,
                                           logic [30:0] draw);
        t_canon      r;
        logic [63:0] d, n, m, an, ad, g, f;
        logic [31:0] mag;
        logic        neg;
        r = '{default: '0};
        neg = 1'b0;
        d = 64'(draw);
        if (d == 0 || fc > trpc_pkg::FC_CSC) return r;
        m = (fc == trpc_pkg::FC_TAN || fc == trpc_pkg::FC_COT) ? d : 2 * d;
        if (nraw[31]) begin
            mag = -nraw;
            n = 64'(mag) % m;
            if (n != 0) n = m - n;
        end else begin
            n = 64'(nraw) % m;
        end
        if (fc == trpc_pkg::FC_TAN || fc == trpc_pkg::FC_COT) begin
            if (2 * n > d) begin neg = 1'b1; n = d - n; end
        end else if (fc == trpc_pkg::FC_SIN || fc == trpc_pkg::FC_CSC) begin
            if (n > d) begin neg = 1'b1; n = n - d; end
            if (2 * n > d) n = d - n;
        end else begin
            if (n > d) n = m - n;
            if (2 * n > d) begin neg = 1'b1; n = d - n; end
        end
        g = gcd64(n, d);
        if (g > 1) begin n = n / g; d = d / g; end
        r.valid_res = 1'b1;
        r.negate = neg;
        r.func_out = fc;
        r.numer_out = n[30:0];
        r.denom_out = d[31:0];
        if (n == 0) begin
            r.denom_out = 32'd1;
        end else begin
            an = d - 2 * n;
            ad = 2 * d;
            g = gcd64(an, ad);
            if (g > 1) begin an = an / g; ad = ad / g; end
            if (an == 0) ad = 1;
            if (an < n) begin
                f = 64'(fc) ^ 64'd1;
                r.func_out = f[2:0];
                r.numer_out = an[30:0];
                r.denom_out = ad[31:0];
            end
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_canon e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angle_q.size() == 0) begin
                $display("%0t unexpected beat: valid_res=%0d func=%0d %0d/%0d neg=%0d",
                         $time, o_valid_res, o_func_out, o_numer_out, o_denom_out,
                         o_negate);
                errors++;
            end else begin
                e = angle_q.pop_front();
                n_checked++;
                if (o_valid_res !== e.valid_res || o_func_out !== e.func_out ||
                    o_numer_out !== e.numer_out || o_denom_out !== e.denom_out ||
                    o_negate !== e.negate) begin
                    $display("%0t mismatch: exp vr=%0d f=%0d %0d/%0d neg=%0d",
                             $time, e.valid_res, e.func_out, e.numer_out,
                             e.denom_out, e.negate);
                    $display("%0t           got vr=%0d f=%0d %0d/%0d neg=%0d",
                             $time, o_valid_res, o_func_out, o_numer_out,
                             o_denom_out, o_negate);
                    errors++;
                end
            end
        end
    end

    task automatic send_angle(logic [2:0] fc, logic [31:0] nm, logic [30:0] dn);
        t_canon e;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func_code <= fc;
        i_numer <= nm;
        i_denom <= dn;
        do @(posedge i_clk); while (o_stall);
        e = canon_angle(fc, nm, dn);
        angle_q.push_back(e);
        n_sent++;
        if (!e.valid_res) n_rejected++;
        else if (e.func_out != fc) n_swapped++;
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic [2:0] fc;
        for (int k = 0; k <= 5; k++) begin
            fc = 3'(k);
            send_angle(fc, 32'd0, 31'd1);
            send_angle(fc, 32'd1, 31'd1);
            send_angle(fc, 32'd1, 31'd3);
        end
        send_angle(trpc_pkg::FC_TAN, 32'd1, 31'd4);
        send_angle(trpc_pkg::FC_COT, 32'hFFFF_FFFF, 31'd6);
        send_angle(trpc_pkg::FC_SIN, 32'd1, 31'd2);
        send_angle(trpc_pkg::FC_SEC, 32'h8000_0000, 31'h7FFF_FFFF);
        send_angle(trpc_pkg::FC_CSC, 32'h7FFF_FFFF, 31'h7FFF_FFFE);
        send_angle(trpc_pkg::FC_COS, 32'd5, 31'd0);
        send_angle(3'd6, 32'd1, 31'd3);
        send_angle(3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        idle_input();
    endtask

    function automatic logic [30:0] pick_denom();
        case ($urandom_range(3))
            0: return 31'($urandom_range(12));
            1: return 31'($urandom_range(360, 1));
            2: return 31'($urandom);
            default: return 31'($urandom_range(4096));
        endcase
    endfunction

    function automatic logic [31:0] pick_numer(logic [30:0] dn);
        case ($urandom_range(2))
            0: return 32'($signed($urandom_range(64)) - 32);
            1: return 32'($signed(32'(dn)) * ($signed($urandom_range(8)) - 4)
                          + $signed($urandom_range(3)) - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random(int count);
        logic [30:0] dn;
        logic [2:0]  fc;
        for (int k = 0; k < count; k++) begin
            dn = pick_denom();
            fc = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5));
            send_angle(fc, pick_numer(dn), dn);
        end
        idle_input();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
        test_random(10);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        idle_pct = 0;  stall_pct = 0;  test_random(RAND_ITEMS / 4);
        idle_pct = 72; stall_pct = 0;  test_random(RAND_ITEMS / 4);
        idle_pct = 0;  stall_pct = 72; test_random(RAND_ITEMS / 4);
        idle_pct = 25; stall_pct = 25; test_random(RAND_ITEMS / 4);
        stall_pct = 0;
        while (angle_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("%0d angles sent across all six functions, %0d checked, %0d rejected,",
                 n_sent, n_checked, n_rejected);
        $display("%0d resolved to the complementary function; %0d errors",
                 n_swapped, errors);
        if (errors == 0 && angle_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
